[hdl/adcbcd_pkg.sv]
// Shared types, widths and the seven-segment code table for the display scanner.
`default_nettype none

package adcbcd_pkg;

  localparam int VALUE_W  = 12;
  localparam int DWELL_W  = 8;
  localparam int DIGIT_W  = 4;
  localparam int SEG_W    = 7;
  // divide by ten as (v * DIV10_MUL) >> DIV10_SHIFT, exact for 12-bit values
  localparam int DIV10_MUL   = 3277;
  localparam int DIV10_SHIFT = 15;
  localparam int PROD_W      = 24;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [SEG_W-1:0]   seg_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [DWELL_W-1:0] dwell_t;

  // register index, decoded from paddr[2]
  typedef enum logic [0:0] {REG_LONG_DWELL, REG_SHORT_DWELL} dwell_reg_t;

  // per-word control produced by the scan sequencer
  typedef struct packed {
    logic blank;  // display dark, converter off
    logic conv;   // first tick of a scan
  } scan_info_t;

  function automatic seg_t seg_decode(input digit_t d);
    seg_t s;
    case (d)
      4'd0:    s = 7'h3f;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5b;
      4'd3:    s = 7'h4f;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6d;
      4'd6:    s = 7'h7d;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7f;
      4'd9:    s = 7'h67;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[hdl/adcbcd_div10.sv]
// One digit-split step: quotient and remainder of a 12-bit value by ten.
`default_nettype none

module adcbcd_div10
  import adcbcd_pkg::*;
(
  input  wire value_t value,
  output value_t      quot,
  output digit_t      rem
);

  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] times10;

  always_comb begin
    prod    = PROD_W'(value) * PROD_W'(DIV10_MUL);
    quot    = VALUE_W'(prod >> DIV10_SHIFT);
    times10 = (quot << 3) + (quot << 1);
    rem     = DIGIT_W'(value - times10);
  end

endmodule

`default_nettype wire

[hdl/adcbcd_scan.sv]
// Scan sequencer: digit position, dwell counter, sleep and wake handling.
`default_nettype none

module adcbcd_scan
  import adcbcd_pkg::*;
#(
  parameter int DIGIT_COUNT = 4,
  parameter int PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          adv,
  input  wire          light,
  input  wire          wake,
  input  wire dwell_t  long_dwell,
  input  wire dwell_t  short_dwell,
  output scan_info_t   info,
  output logic [PW-1:0] pos_out
);

  logic [PW-1:0] pos, pos_next;
  dwell_t        cnt, cnt_next;
  logic          asleep, asleep_next;
  logic          last_wake;

  logic          falling, woke;
  dwell_t        dsel, cnt_eff;
  logic [PW-1:0] pos_w;

  always_comb begin
    falling     = last_wake & ~wake;
    woke        = 1'b0;
    info.blank  = 1'b0;
    info.conv   = 1'b0;
    asleep_next = asleep;
    pos_w       = pos;
    cnt_eff     = cnt;
    dsel        = (pos == PW'(DIGIT_COUNT - 1)) ? short_dwell : long_dwell;
    if (asleep) begin
      if (!falling) begin
        info.blank = 1'b1;
      end else begin
        asleep_next = 1'b0;
        woke        = 1'b1;
        pos_w       = '0;
        cnt_eff     = '0;
        dsel        = (DIGIT_COUNT == 1) ? short_dwell : long_dwell;
      end
    end
    if (!info.blank && cnt_eff == '0) begin
      if (pos_w == '0) begin
        if (!light && !woke) begin
          asleep_next = 1'b1;
          info.blank  = 1'b1;
        end else begin
          info.conv = 1'b1;
        end
      end
      if (!info.blank) begin
        cnt_eff = (dsel == '0) ? dwell_t'(1) : dsel;
      end
    end
    pos_next = pos_w;
    cnt_next = cnt_eff;
    if (!info.blank) begin
      cnt_next = cnt_eff - dwell_t'(1);
      if (cnt_next == '0) begin
        pos_next = (pos_w == PW'(DIGIT_COUNT - 1)) ? '0 : pos_w + PW'(1);
      end
    end
    pos_out = pos_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      cnt       <= '0;
      asleep    <= 1'b0;
      last_wake <= 1'b1;
    end else if (adv) begin
      pos       <= pos_next;
      cnt       <= cnt_next;
      asleep    <= asleep_next;
      last_wake <= wake;
    end
  end

endmodule

`default_nettype wire

[hdl/adc_bcd_seven_segment_scanner_core.sv]
// Top level: converter result to decimal digits, multiplexed seven-segment scan.
//
//   port group   dir  word contents (low bit first)
//   s_axis       in   tuser: sample_valid; tdata: sample_value[11:0], light_strong,
//                     wake_pin, zero fill to 16
//   m_axis       out  tdata: common_drive[DIGIT_COUNT-1:0], segment_drive[6:0],
//                     convert_start, converter_on, zero fill to whole bytes
//   apb          in   0x0 long_dwell, 0x4 short_dwell (8 bits each)
//
// One word is accepted per cycle while the output is not stalled. A result passes
// through the input register, the scan sequencer, then DIGIT_COUNT-1
// divide-by-ten stages, then the output register.
// Every stage holds its word until the next one frees up, so a stalled output
// backs up stage by stage while bubbles still let new words in.
// Synchronous reset clears handshake valids, the scan state, the digit store
// and loads the dwell registers with 20 and 10.
`default_nettype none

module adc_bcd_seven_segment_scanner_core
  import adcbcd_pkg::*;
#(
  parameter int DIGIT_COUNT = 4
) (
  input  wire        clk,
  input  wire        rst,
  // input stream
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [15:0] s_tdata,   // sample_value[11:0], light_strong, wake_pin
  input  wire        s_tuser,   // sample_valid
  // output stream
  output logic       m_tvalid,
  input  wire        m_tready,
  // common_drive, segment_drive, convert_start, converter_on
  output logic [((DIGIT_COUNT + 16) / 8) * 8 - 1:0] m_tdata,
  // register port
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [2:0]  paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  localparam int PW    = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int L     = DIGIT_COUNT;               // pipeline stages after s0
  localparam int OUT_W = ((DIGIT_COUNT + 16) / 8) * 8;
  localparam int PAY_W = DIGIT_COUNT + SEG_W + 2;

  // ---------------- configuration registers ----------------
  dwell_t     long_dwell, short_dwell;
  dwell_reg_t reg_sel;
  logic       addr_ok;

  assign pready  = 1'b1;
  assign reg_sel = dwell_reg_t'(paddr[2]);
  assign addr_ok = (paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      long_dwell  <= dwell_t'(20);
      short_dwell <= dwell_t'(10);
    end else if (psel && penable && pwrite && pready && addr_ok) begin
      case (reg_sel)
        REG_LONG_DWELL:  long_dwell  <= pwdata[DWELL_W-1:0];
        REG_SHORT_DWELL: short_dwell <= pwdata[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (addr_ok) begin
      case (reg_sel)
        REG_LONG_DWELL:  prdata = 32'(long_dwell);
        REG_SHORT_DWELL: prdata = 32'(short_dwell);
        default:         prdata = '0;
      endcase
    end
  end

  // ---------------- input register (s0) ----------------
  logic   in_v;
  logic   in_sv, in_light, in_wake;
  value_t in_val;
  logic   adv0;

  // ---------------- pipeline stages 1..L ----------------
  logic              st_v    [1:L];
  logic              st_sv   [1:L];
  scan_info_t        st_info [1:L];
  logic [PW-1:0]     st_pos  [1:L];
  value_t            st_val  [1:L];
  digit_t            st_dig  [1:L][DIGIT_COUNT];
  logic              rdy     [1:L];

  logic out_v;
  logic rdy_out;

  assign rdy_out  = !out_v || m_tready;
  assign s_tready = !in_v || rdy[1];
  assign adv0     = in_v && rdy[1];

  always_comb begin
    for (int k = 1; k <= L; k++) begin
      if (k == L) begin
        rdy[k] = !st_v[k] || rdy_out;
      end else begin
        rdy[k] = !st_v[k] || rdy[(k < L) ? k + 1 : L];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sv    <= s_tuser;
      in_val   <= s_tdata[VALUE_W-1:0];
      in_light <= s_tdata[12];
      in_wake  <= s_tdata[13];
    end
  end

  // scan sequencer works on the word leaving s0
  scan_info_t    scan_info;
  logic [PW-1:0] scan_pos;

  adcbcd_scan #(
    .DIGIT_COUNT (DIGIT_COUNT),
    .PW          (PW)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv0),
    .light       (in_light),
    .wake        (in_wake),
    .long_dwell  (long_dwell),
    .short_dwell (short_dwell),
    .info        (scan_info),
    .pos_out     (scan_pos)
  );

  // stage 1 loads from s0
  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[1] <= 1'b0;
    end else if (rdy[1]) begin
      st_v[1] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      st_sv[1]   <= in_sv;
      st_info[1] <= scan_info;
      st_pos[1]  <= scan_pos;
      st_val[1]  <= in_val;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        st_dig[1][i] <= '0;
      end
    end
  end

  // one decimal digit peeled off per stage, units first
  for (genvar k = 1; k < L; k++) begin : g_div
    value_t q;
    digit_t r;

    adcbcd_div10 u_div (
      .value (st_val[k]),
      .quot  (q),
      .rem   (r)
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k+1] <= 1'b0;
      end else if (rdy[k+1]) begin
        st_v[k+1] <= st_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (st_v[k] && rdy[k+1]) begin
        st_sv[k+1]   <= st_sv[k];
        st_info[k+1] <= st_info[k];
        st_pos[k+1]  <= st_pos[k];
        st_val[k+1]  <= q;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          st_dig[k+1][i] <= (i == k - 1) ? r : st_dig[k][i];
        end
      end
    end
  end

  // ---------------- digit store and output register ----------------
  digit_t digit_store [DIGIT_COUNT];
  digit_t fin_dig     [DIGIT_COUNT];
  digit_t shown;
  logic   out_ld;
  logic [DIGIT_COUNT-1:0] common_n;
  seg_t   seg_n;
  logic [PAY_W-1:0] out_pay;

  assign out_ld = st_v[L] && rdy_out;

  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      fin_dig[i] = st_dig[L][i];
    end
    // most significant position keeps the whole remaining quotient, clamped
    fin_dig[DIGIT_COUNT-1] = (st_val[L] > value_t'(15)) ? digit_t'(15)
                                                         : st_val[L][DIGIT_W-1:0];
    // a fresh sample on this word is displayed at once
    shown    = st_sv[L] ? fin_dig[st_pos[L]] : digit_store[st_pos[L]];
    common_n = DIGIT_COUNT'(1) << (PW'(DIGIT_COUNT - 1) - st_pos[L]);
    seg_n    = seg_decode(shown);
    if (st_info[L].blank) begin
      common_n = '0;
      seg_n    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_store[i] <= '0;
      end
    end else if (out_ld && st_sv[L]) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_store[i] <= fin_dig[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (rdy_out) begin
      out_v <= st_v[L];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_pay <= {!st_info[L].blank, st_info[L].conv, seg_n, common_n};
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = OUT_W'(out_pay);

endmodule

`default_nettype wire
